// ===== src/gpe_pkg.sv =====
// gpe_pkg: shared types, constants and the 2^-x table for the gaussian profile evaluator.
// No dependencies; imported by every module under src.
package gpe_pkg;

    localparam int DATA_W    = 32;
    localparam int WIDTH_W   = 31;
    localparam int NUM_W     = 64;
    localparam int DEN_W     = 63;
    localparam int EXP_FRAC  = 26;
    localparam int TAB_BITS  = 4;
    localparam int LERP_BITS = EXP_FRAC - TAB_BITS;
    localparam int INT_QBITS = 5;
    localparam int QUOT_BITS = INT_QBITS + EXP_FRAC;
    localparam int MANT_W    = 31;
    localparam int EXPO_W    = 6;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

    typedef enum logic [1:0] {
        CFG_AMPLITUDE = 2'd0,
        CFG_CENTER    = 2'd1,
        CFG_WIDTH     = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     last_in;
    } sample_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_out;
    } result_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic zero;
    } ctl_t;

    // 2^(-i/16) in Q30, i = 0..16
    function automatic logic [MANT_W-1:0] pow2_neg(input logic [TAB_BITS:0] idx);
        logic [MANT_W-1:0] v;
        unique case (idx)
            5'd0:    v = 31'd1073741824;
            5'd1:    v = 31'd1028218693;
            5'd2:    v = 31'd984625594;
            5'd3:    v = 31'd942880699;
            5'd4:    v = 31'd902905651;
            5'd5:    v = 31'd864625413;
            5'd6:    v = 31'd827968132;
            5'd7:    v = 31'd792865000;
            5'd8:    v = 31'd759250125;
            5'd9:    v = 31'd727060411;
            5'd10:   v = 31'd696235434;
            5'd11:   v = 31'd666717336;
            5'd12:   v = 31'd638450708;
            5'd13:   v = 31'd611382493;
            5'd14:   v = 31'd585461881;
            5'd15:   v = 31'd560640218;
            default: v = 31'd536870912;
        endcase
        return v;
    endfunction

endpackage

// ===== src/gaussian_profile_eval_top.sv =====
// Gaussian profile evaluator: value = i0 * exp(-(x - mu)^2 / (2 * sigma^2)) in signed Q16.16.
//
// Channels: sample_* takes one x (plus a last flag) per transfer; result_* returns one value
// per sample, in order, with last_out copied from last_in. Both use valid/stall: a transfer
// happens on a clock edge with valid high and stall low.
// Configuration: cfg_* writes amplitude (index 0), center (1) or width (2, low 31 bits) on an
// edge with cfg_valid and cfg_ready high; cfg_ready is always high, other indexes are dropped.
// Write registers only while no samples are in flight.
// Throughput: one sample per cycle while sample_stall is low. The path runs through the
// 31-stage restoring divider (one quotient bit per stage) plus 12 other stages.
// Stall: when the receiver stalls, one more result lands in a skid entry, then the whole
// pipeline freezes and sample_stall rises; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous): pipeline emptied, amplitude = 1.0, center = 0, width = 1.0.
// Depends on gpe_pkg, gpe_front, gpe_divider, gpe_exp2, gpe_scale, gpe_outbuf.
module gaussian_profile_eval_top import gpe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         sample_valid,
    output logic         sample_stall,
    input  sample_t      sample_item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_t      result_item,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    logic [DATA_W-1:0]    amplitude_reg;
    logic [DATA_W-1:0]    center_reg;
    logic [WIDTH_W-1:0]   width_reg;
    logic                 en;
    ctl_t                 front_ctl;
    logic [NUM_W-1:0]     front_num;
    logic [DEN_W-1:0]     front_den;
    ctl_t                 div_ctl;
    logic [QUOT_BITS-1:0] div_quot;
    ctl_t                 exp_ctl;
    logic [MANT_W-1:0]    exp_mant;
    logic [EXPO_W-1:0]    exp_expo;
    logic                 pipe_valid;
    result_t              pipe_item;

    assign cfg_ready    = 1'b1;
    assign sample_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg <= DATA_W'(65536);
            center_reg    <= '0;
            width_reg     <= WIDTH_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_AMPLITUDE: amplitude_reg <= cfg_data;
                CFG_CENTER:    center_reg    <= cfg_data;
                CFG_WIDTH:     width_reg     <= cfg_data[WIDTH_W-1:0];
                default:       ;
            endcase
        end
    end

    gpe_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .sample_valid (sample_valid),
        .sample_item  (sample_item),
        .center       (center_reg),
        .width        (width_reg),
        .ctl          (front_ctl),
        .num          (front_num),
        .den          (front_den)
    );

    gpe_divider u_divider
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .ctl_in (front_ctl),
        .num    (front_num),
        .den    (front_den),
        .ctl    (div_ctl),
        .quot   (div_quot)
    );

    gpe_exp2 u_exp2
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .ctl_in (div_ctl),
        .quot   (div_quot),
        .ctl    (exp_ctl),
        .mant   (exp_mant),
        .expo   (exp_expo)
    );

    gpe_scale u_scale
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .ctl_in     (exp_ctl),
        .mant       (exp_mant),
        .expo       (exp_expo),
        .amplitude  (amplitude_reg),
        .pipe_valid (pipe_valid),
        .pipe_item  (pipe_item)
    );

    gpe_outbuf u_outbuf
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pipe_valid   (pipe_valid),
        .pipe_item    (pipe_item),
        .en           (en),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

// ===== src/gpe_front.sv =====
// gpe_front: distance to center, squared distance and 2*sigma^2, far-exponent flag.
// Three register stages; depends on gpe_pkg.
module gpe_front import gpe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                sample_valid,
    input  sample_t             sample_item,
    input  logic [DATA_W-1:0]   center,
    input  logic [WIDTH_W-1:0]  width,
    output ctl_t                ctl,
    output logic [NUM_W-1:0]    num,
    output logic [DEN_W-1:0]    den
);

    logic [DATA_W:0]     diff_next;
    logic [DATA_W:0]     abs_next;
    logic [DATA_W-1:0]   dist_next;
    logic [DATA_W-1:0]   dist_reg;
    ctl_t                ctl_a_next;
    ctl_t                ctl_a_reg;
    ctl_t                ctl_b_reg;
    ctl_t                ctl_c_next;
    ctl_t                ctl_c_reg;
    logic [WIDTH_W-1:0]  sigma;
    logic [2*WIDTH_W-1:0] sq_next;
    logic [NUM_W-1:0]    num_next;
    logic [NUM_W-1:0]    num_b_reg;
    logic [DEN_W-1:0]    den_b_reg;
    logic [NUM_W-1:0]    num_c_reg;
    logic [DEN_W-1:0]    den_c_reg;

    always_comb
    begin
        diff_next  = {sample_item.sample[DATA_W-1], sample_item.sample}
                   - {center[DATA_W-1], center};
        abs_next   = diff_next[DATA_W] ? ((DATA_W+1)'(0) - diff_next) : diff_next;
        dist_next  = abs_next[DATA_W-1:0];
        ctl_a_next = '{valid: sample_valid, last: sample_item.last_in, zero: 1'b0};
        // sigma of zero behaves as one LSB
        sigma      = (width == '0) ? WIDTH_W'(1) : width;
        sq_next    = (2*WIDTH_W)'(sigma) * (2*WIDTH_W)'(sigma);
        num_next   = NUM_W'(dist_reg) * NUM_W'(dist_reg);
        ctl_c_next = ctl_b_reg;
        // integer part of the exponent at least 32
        ctl_c_next.zero = {4'b0, num_b_reg} >= {den_b_reg, 5'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
        end
        else if (en)
        begin
            ctl_a_reg <= ctl_a_next;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg  <= dist_next;
            num_b_reg <= num_next;
            den_b_reg <= {sq_next, 1'b0};
            num_c_reg <= num_b_reg;
            den_c_reg <= den_b_reg;
        end
    end

    assign ctl = ctl_c_reg;
    assign num = num_c_reg;
    assign den = den_c_reg;

endmodule

// ===== src/gpe_divider.sv =====
// gpe_divider: restoring divider, one quotient bit per stage, gives floor(num * 2^26 / den).
// QUOT_BITS register stages; depends on gpe_pkg.
module gpe_divider import gpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  ctl_t                  ctl_in,
    input  logic [NUM_W-1:0]      num,
    input  logic [DEN_W-1:0]      den,
    output ctl_t                  ctl,
    output logic [QUOT_BITS-1:0]  quot
);

    ctl_t                 ctl_reg [QUOT_BITS];
    logic [NUM_W-1:0]     rem_reg [QUOT_BITS];
    logic [DEN_W-1:0]     dd_reg  [QUOT_BITS];
    logic [QUOT_BITS-1:0] q_reg   [QUOT_BITS];

    for (genvar k = 0; k < QUOT_BITS; k++)
    begin : g_stage
        ctl_t                 ctl_cur;
        logic [NUM_W-1:0]     rem_cur;
        logic [DEN_W-1:0]     den_cur;
        logic [QUOT_BITS-1:0] q_cur;
        logic [NUM_W-1:0]     rem_next;
        logic                 bit_next;

        if (k == 0)
        begin : g_first
            assign ctl_cur = ctl_in;
            assign rem_cur = num;
            assign den_cur = den;
            assign q_cur   = '0;
        end
        else
        begin : g_chain
            assign ctl_cur = ctl_reg[k-1];
            assign rem_cur = rem_reg[k-1];
            assign den_cur = dd_reg[k-1];
            assign q_cur   = q_reg[k-1];
        end

        if (k < INT_QBITS)
        begin : g_int
            // integer bits: compare against den shifted up
            localparam int SH = INT_QBITS - 1 - k;
            logic [NUM_W+3:0] trial;
            logic [NUM_W+3:0] wide_rem;
            logic [NUM_W+3:0] wide_diff;
            assign trial     = {5'b0, den_cur} << SH;
            assign wide_rem  = {4'b0, rem_cur};
            assign bit_next  = wide_rem >= trial;
            assign wide_diff = wide_rem - trial;
            assign rem_next  = bit_next ? wide_diff[NUM_W-1:0] : rem_cur;
        end
        else
        begin : g_frac
            // remainder is below den here, so doubling fits
            logic [NUM_W-1:0] dbl;
            logic [NUM_W-1:0] dext;
            assign dbl      = {rem_cur[NUM_W-2:0], 1'b0};
            assign dext     = {1'b0, den_cur};
            assign bit_next = dbl >= dext;
            assign rem_next = bit_next ? (dbl - dext) : dbl;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else if (en)
            begin
                ctl_reg[k] <= ctl_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                dd_reg[k]  <= den_cur;
                q_reg[k]   <= {q_cur[QUOT_BITS-2:0], bit_next};
            end
        end
    end

    assign ctl  = ctl_reg[QUOT_BITS-1];
    assign quot = q_reg[QUOT_BITS-1];

endmodule

// ===== src/gpe_exp2.sv =====
// gpe_exp2: converts the exponent to base 2 and evaluates 2^-f by table and interpolation.
// Five register stages; depends on gpe_pkg.
module gpe_exp2 import gpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  ctl_t                  ctl_in,
    input  logic [QUOT_BITS-1:0]  quot,
    output ctl_t                  ctl,
    output logic [MANT_W-1:0]     mant,
    output logic [EXPO_W-1:0]     expo
);

    localparam int PY_W    = 2 * QUOT_BITS;
    localparam int Y_W     = EXPO_W + EXP_FRAC;
    localparam int DELTA_W = LERP_BITS + TAB_BITS;
    localparam int IP_W    = DELTA_W + LERP_BITS;

    ctl_t                 ctl1_reg;
    ctl_t                 ctl2_reg;
    ctl_t                 ctl3_reg;
    ctl_t                 ctl4_reg;
    ctl_t                 ctl5_reg;
    logic [PY_W-1:0]      py_next;
    logic [PY_W-1:0]      py_reg;
    logic [PY_W-1:0]      ysum;
    logic [Y_W-1:0]       y_reg;
    logic [TAB_BITS:0]    idx;
    logic [MANT_W-1:0]    a_next;
    logic [MANT_W-1:0]    b_next;
    logic [MANT_W-1:0]    delta_full;
    logic [MANT_W-1:0]    a3_reg;
    logic [DELTA_W-1:0]   delta_reg;
    logic [LERP_BITS-1:0] lo_reg;
    logic [EXPO_W-1:0]    n3_reg;
    logic [IP_W-1:0]      ip_next;
    logic [IP_W-1:0]      ip_reg;
    logic [MANT_W-1:0]    a4_reg;
    logic [EXPO_W-1:0]    n4_reg;
    logic [MANT_W-1:0]    m_next;
    logic [MANT_W-1:0]    m_reg;
    logic [EXPO_W-1:0]    n5_reg;

    always_comb
    begin
        py_next    = PY_W'(quot) * PY_W'(LOG2E_Q30);
        ysum       = py_reg + (PY_W'(1) << 29);
        idx        = {1'b0, y_reg[EXP_FRAC-1:LERP_BITS]};
        a_next     = pow2_neg(idx);
        b_next     = pow2_neg(idx + (TAB_BITS+1)'(1));
        delta_full = a_next - b_next;
        ip_next    = IP_W'(delta_reg) * IP_W'(lo_reg);
        m_next     = a4_reg - MANT_W'(ip_reg[IP_W-1:LERP_BITS]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            py_reg    <= py_next;
            y_reg     <= ysum[PY_W-1:30];
            a3_reg    <= a_next;
            delta_reg <= delta_full[DELTA_W-1:0];
            lo_reg    <= y_reg[LERP_BITS-1:0];
            n3_reg    <= y_reg[Y_W-1:EXP_FRAC];
            ip_reg    <= ip_next;
            a4_reg    <= a3_reg;
            n4_reg    <= n3_reg;
            m_reg     <= m_next;
            n5_reg    <= n4_reg;
        end
    end

    assign ctl  = ctl5_reg;
    assign mant = m_reg;
    assign expo = n5_reg;

endmodule

// ===== src/gpe_scale.sv =====
// gpe_scale: scales |i0| by the mantissa, shifts by the exponent with rounding, restores sign.
// Three register stages; depends on gpe_pkg.
module gpe_scale import gpe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  ctl_t               ctl_in,
    input  logic [MANT_W-1:0]  mant,
    input  logic [EXPO_W-1:0]  expo,
    input  logic [DATA_W-1:0]  amplitude,
    output logic               pipe_valid,
    output result_t            pipe_item
);

    localparam int PROD_W = DATA_W + MANT_W;
    localparam int SH_W   = EXPO_W + 1;

    logic [DATA_W-1:0]  mag_next;
    logic [DATA_W-1:0]  mag_reg;
    logic               neg_reg;
    logic [PROD_W-1:0]  prod_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [EXPO_W-1:0]  n6_reg;
    ctl_t               ctl6_reg;
    logic [SH_W-1:0]    sh;
    logic [NUM_W-1:0]   rnd;
    logic [NUM_W-1:0]   rsum;
    logic [NUM_W-1:0]   rshift;
    ctl_t               ctl7_next;
    ctl_t               ctl7_reg;
    logic [DATA_W-1:0]  r_reg;
    logic [DATA_W-1:0]  val_next;
    logic               valid8_reg;
    result_t            item_reg;

    always_comb
    begin
        mag_next  = amplitude[DATA_W-1] ? (DATA_W'(0) - amplitude) : amplitude;
        prod_next = PROD_W'(mag_reg) * PROD_W'(mant);
        sh        = SH_W'(30) + {1'b0, n6_reg};
        rnd       = NUM_W'(1) << (sh - SH_W'(1));
        rsum      = {1'b0, prod_reg} + rnd;
        rshift    = rsum >> sh;
        ctl7_next = ctl6_reg;
        // shift beyond the product width rounds to zero
        ctl7_next.zero = ctl6_reg.zero | (sh > SH_W'(63));
        if (ctl7_reg.zero)
        begin
            val_next = '0;
        end
        else if (neg_reg)
        begin
            val_next = DATA_W'(0) - r_reg;
        end
        else
        begin
            val_next = r_reg;
        end
    end

    // the user must keep amplitude static while items are in flight; this block does not enforce it
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        neg_reg <= amplitude[DATA_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl6_reg   <= '0;
            ctl7_reg   <= '0;
            valid8_reg <= 1'b0;
        end
        else if (en)
        begin
            ctl6_reg   <= ctl_in;
            ctl7_reg   <= ctl7_next;
            valid8_reg <= ctl7_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg          <= prod_next;
            n6_reg            <= expo;
            r_reg             <= rshift[DATA_W-1:0];
            item_reg.value    <= val_next;
            item_reg.last_out <= ctl7_reg.last;
        end
    end

    assign pipe_valid = valid8_reg;
    assign pipe_item  = item_reg;

endmodule

// ===== src/gpe_outbuf.sv =====
// gpe_outbuf: output register plus one skid entry; the pipeline enable comes from skid occupancy.
// Depends on gpe_pkg.
module gpe_outbuf import gpe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pipe_valid,
    input  result_t  pipe_item,
    output logic     en,
    output logic     result_valid,
    input  logic     result_stall,
    output result_t  result_item
);

    logic     out_valid_reg;
    logic     out_valid_next;
    result_t  out_item_reg;
    logic     skid_valid_reg;
    logic     skid_valid_next;
    result_t  skid_item_reg;
    logic     take;
    logic     pipe_xfer;

    assign en        = !skid_valid_reg;
    assign take      = !out_valid_reg || !result_stall;
    assign pipe_xfer = pipe_valid && en;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = pipe_xfer;
            end
        end
        else if (pipe_xfer)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_item_reg <= skid_valid_reg ? skid_item_reg : pipe_item;
        end
        else if (pipe_xfer)
        begin
            skid_item_reg <= pipe_item;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

endmodule

// ===== verif/tb.sv =====
// tb: self-checking bench for gaussian_profile_eval_top, with its own fixed-point gaussian
// predictor in a scoreboard class, directed corner samples, then randomized register phases.
// Depends on gpe_pkg (payload structs, register index enum) and the RTL under src.
module tb;
    import gpe_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned NUM_PHASES  = 12;
    localparam int unsigned PHASE_ITEMS = 155;
    localparam int unsigned DRAIN_WAIT  = 60;
    localparam logic [1:0]  CFG_SPARE   = 2'd3;
    localparam logic [63:0] LOG2E_FIX   = 64'd1549082005;

    // 2^(-i/16), Q30
    localparam logic [31:0] POW2_NEG_Q30 [17] = '{
        32'd1073741824, 32'd1028218693, 32'd984625594, 32'd942880699,
        32'd902905651,  32'd864625413,  32'd827968132, 32'd792865000,
        32'd759250125,  32'd727060411,  32'd696235434, 32'd666717336,
        32'd638450708,  32'd611382493,  32'd585461881, 32'd560640218,
        32'd536870912
    };

    class profile_checker;
        logic [31:0] amp_reg;
        logic [31:0] center_reg;
        logic [30:0] width_reg;
        result_t     pending_values[$];
        int unsigned checked;
        int unsigned mismatches;

        function void reset_regs();
            amp_reg    = 32'd65536;
            center_reg = 32'd0;
            width_reg  = 31'd65536;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_AMPLITUDE: amp_reg    = data;
                CFG_CENTER:    center_reg = data;
                CFG_WIDTH:     width_reg  = data[30:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] gauss_value(logic [31:0] x);
            logic signed [33:0] diff;
            logic [63:0] d, s, num, den, ip, rem, q, y, f, lo, mag, prod, r, n, sh;
            logic [31:0] a, b, m;
            logic [3:0]  idx;
            int          k;
            diff = $signed({{2{x[31]}}, x}) - $signed({{2{center_reg[31]}}, center_reg});
            d    = diff[33] ? 64'(-diff) : 64'(diff);
            s    = (width_reg == 31'd0) ? 64'd1 : 64'(width_reg);
            num  = d * d;
            den  = (s * s) << 1;
            ip   = num / den;
            rem  = num % den;
            if (ip >= 64'd32)
                return 32'd0;
            q = ip;
            for (k = 0; k < 26; k++)
            begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= den)
                begin
                    rem  = rem - den;
                    q[0] = 1'b1;
                end
            end
            y   = (q * LOG2E_FIX + (64'd1 << 29)) >> 30;
            n   = y >> 26;
            f   = y & ((64'd1 << 26) - 64'd1);
            idx = f[25:22];
            lo  = {42'd0, f[21:0]};
            a   = POW2_NEG_Q30[int'(idx)];
            b   = POW2_NEG_Q30[int'(idx) + 1];
            m   = a - 32'((64'(a - b) * lo) >> 22);
            mag = amp_reg[31] ? (64'd1 << 32) - 64'(amp_reg) : 64'(amp_reg);
            prod = mag * 64'(m);
            sh  = 64'd30 + n;
            if (sh > 64'd63)
                return 32'd0;
            r = (prod + (64'd1 << (sh - 64'd1))) >> sh;
            if (amp_reg[31])
                r = 64'd0 - r;
            return r[31:0];
        endfunction

        function void note_sample(sample_t s);
            result_t r;
            r.value    = gauss_value(s.sample);
            r.last_out = s.last_in;
            pending_values.push_back(r);
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", what, want, got);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_values.size() == 0)
            begin
                flag("unexpected result value", 32'd0, got.value);
                return;
            end
            want = pending_values.pop_front();
            checked++;
            if (got.value !== want.value)
                flag("value", want.value, got.value);
            if (got.last_out !== want.last_out)
                flag("last_out", 32'(want.last_out), 32'(got.last_out));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        sample_valid = 1'b0;
    logic        sample_stall;
    sample_t     sample_item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'd0;

    profile_checker sb = new;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned samples_sent = 0;
    int unsigned settings_used = 1;
    int unsigned cycle_count = 0;

    gaussian_profile_eval_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_item  (sample_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result_item);

    task automatic set_traffic(int unsigned mode);
        case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 66; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 66; end
            default: begin idle_pct = 22; stall_pct = 22; end
        endcase
    endtask

    task automatic send_sample(logic [31:0] x, logic last);
        sample_t s;
        s.sample  = x;
        s.last_in = last;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample_item  <= s;
        do
            @(posedge clk);
        while (sample_stall);
        sb.note_sample(s);
        samples_sent++;
    endtask

    // lower valid, let every expected result arrive, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (sb.pending_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_config();
        logic [31:0] amp;
        logic [31:0] ctr;
        logic [30:0] wid;
        case ($urandom_range(5))
            0: amp = 32'h8000_0000;
            1: amp = 32'h7FFF_FFFF;
            2: amp = 32'd0;
            3: amp = $urandom_range(1, 32'h0010_0000) * ($urandom_range(1) ? 1 : -1);
            default: amp = $urandom;
        endcase
        case ($urandom_range(7))
            0: ctr = 32'h8000_0000;
            1: ctr = 32'h7FFF_FFFF;
            default: ctr = $urandom;
        endcase
        case ($urandom_range(9))
            0: wid = 31'd0;
            1: wid = 31'd1;
            2: wid = 31'h7FFF_FFFF;
            3, 4: wid = 31'($urandom_range(2, 255));
            5, 6: wid = 31'($urandom_range(256, 32'h0010_0000));
            default: wid = 31'($urandom_range(32'h0010_0001, 32'h7FFF_FFFF));
        endcase
        if ($urandom_range(3) == 0)
            write_reg(CFG_SPARE, $urandom);
        write_reg(CFG_AMPLITUDE, amp);
        write_reg(CFG_CENTER, ctr);
        write_reg(CFG_WIDTH, {1'($urandom_range(1)), wid});
        settings_used++;
    endtask

    // mostly within 8.5 sigma of the center, reaching a little past the cutoff at 8 sigma
    function automatic logic [31:0] pick_sample();
        logic [63:0]        s_eff;
        logic [63:0]        span;
        logic signed [63:0] off;
        if ($urandom_range(3) == 0)
            return $urandom;
        s_eff = (sb.width_reg == 31'd0) ? 64'd1 : 64'(sb.width_reg);
        span  = s_eff * 64'd17 / 64'd2 + 64'd1;
        off   = $signed({$urandom, $urandom} % (span * 64'd2 + 64'd1)) - $signed(span);
        return sb.center_reg + off[31:0];
    endfunction

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL gaussian_profile_eval_top");
        $finish;
    end

    initial
    begin
        int unsigned p;
        int unsigned k;
        sb.reset_regs();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: peak, one sigma, ends of range, cutoff edge
        set_traffic(0);
        send_sample(32'd0, 1'b1);
        send_sample(32'd65536, 1'b0);
        send_sample(32'hFFFF_0000, 1'b0);
        send_sample(32'd1, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'd6 << 16, 1'b0);
        send_sample(32'd8 << 16, 1'b0);
        send_sample(32'd523632, 1'b1);
        drain();

        // zero width, most negative amplitude and center
        write_reg(CFG_SPARE, 32'hA5A5_5A5A);
        write_reg(CFG_WIDTH, 32'h8000_0000);
        write_reg(CFG_AMPLITUDE, 32'h8000_0000);
        write_reg(CFG_CENTER, 32'h8000_0000);
        settings_used++;
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h8000_0001, 1'b0);
        send_sample(32'h8000_0003, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b1);
        drain();

        // widest sigma, largest amplitude, largest center
        write_reg(CFG_WIDTH, 32'h7FFF_FFFF);
        write_reg(CFG_AMPLITUDE, 32'h7FFF_FFFF);
        write_reg(CFG_CENTER, 32'h7FFF_FFFF);
        settings_used++;
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'd0, 1'b0);
        send_sample(32'h4000_0000, 1'b1);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            random_config();
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k % 50 == 0)
                    set_traffic((p + k / 50) % 4);
                send_sample(pick_sample(), $urandom_range(7) == 0);
            end
        end
        drain();

        $display("%0d samples sent under %0d register settings and four traffic patterns",
                 samples_sent, settings_used);
        $display("%0d results checked, %0d mismatches, %0d still outstanding",
                 sb.checked, sb.mismatches, sb.pending_values.size());
        if (sb.mismatches == 0 && sb.pending_values.size() == 0)
            $display("PASS gaussian_profile_eval_top");
        else
            $display("FAIL gaussian_profile_eval_top");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/gpe_pkg.sv
src/gpe_front.sv
src/gpe_divider.sv
src/gpe_exp2.sv
src/gpe_scale.sv
src/gpe_outbuf.sv
src/gaussian_profile_eval_top.sv
verif/tb.sv
